>>> rtl/flow_meter_valve_scheduler_macros.svh
// assertion macros for the flow meter valve scheduler
// used by the top level only, no other dependencies
`ifndef FLOW_METER_VALVE_SCHEDULER_MACROS_SVH
`define FLOW_METER_VALVE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define FMVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FMVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fmvs_pkg.sv
// shared types, constants and helpers for the flow meter valve scheduler
// no dependencies
package fmvs_pkg;

  localparam int unsigned MAX_SPANS_DEF = 16;
  localparam int unsigned WINDOWS_DEF   = 4;
  localparam int unsigned DAY_SLOTS_DEF = 7;

  localparam int DVD_W = 36;
  localparam int DVS_W = 16;

  localparam logic [16:0] LAST_SEC  = 17'd86399;
  localparam logic [16:0] SECS_MAX  = 17'h1FFFF;
  localparam logic [47:0] VOL_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] RATE_MUL  = 16'd60000;
  localparam logic [19:0] VOL_MUL   = 20'd1000000;
  localparam logic [18:0] MIN_RECIP = 19'd279621;
  localparam int          MIN_SHIFT = 24;
  localparam logic [15:0] PPL_RST   = 16'd450;
  localparam logic [19:0] THR_RST   = 20'd100;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_OPEN      = 3'd1,
    CMD_CLOSE     = 3'd2,
    CMD_CLR_TOTAL = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PPL    = 2'd0,
    CFG_THR    = 2'd1,
    CFG_WSTART = 2'd2,
    CFG_WEND   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_GO_R,
    ST_DIV_R,
    ST_ROLL,
    ST_GO_V,
    ST_DIV_V,
    ST_UPD,
    ST_CMD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? VOL_MAX : s[47:0];
  endfunction

endpackage

>>> rtl/fmvs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on fmvs_pkg
module fmvs_div import fmvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic             last;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign last  = cnt_q == CNT_W'(DVD_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

>>> rtl/flow_meter_valve_scheduler.sv
// Flow meter valve scheduler, top level: command sequencer, day-slot log memories
// and valve window logic. Depends on fmvs_pkg, fmvs_div and the macros header.
// A tick multiplies, divides for the rate and, if timed, rolls the day; above threshold
// it also divides for the volume before the update. Other words act in ST_CMD.
// One word in flight at a time; the next word is taken the cycle after the result.
// Reset clears the control registers and slot valid bits; neither memory is swept.
`include "flow_meter_valve_scheduler_macros.svh"

module flow_meter_valve_scheduler import fmvs_pkg::*; #(
  parameter int unsigned MAX_SPANS = MAX_SPANS_DEF,
  parameter int unsigned WINDOWS   = WINDOWS_DEF,
  parameter int unsigned DAY_SLOTS = DAY_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [43:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] pulses_i,
  input  logic        time_valid_i,
  input  logic [15:0] day_id_i,
  input  logic [16:0] sec_of_day_i,
  input  logic [2:0]  read_slot_i,
  input  logic [3:0]  read_entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valve_open_o,
  output logic [31:0] flow_rate_o,
  output logic        flow_active_o,
  output logic        override_on_o,
  output logic [16:0] day_active_seconds_o,
  output logic [47:0] day_volume_o,
  output logic [47:0] total_volume_o,
  output logic [4:0]  read_count_o,
  output logic [16:0] read_start_o,
  output logic [16:0] read_end_o,
  output logic [47:0] read_volume_o
);

  localparam int SLOT_W = $clog2(DAY_SLOTS);
  localparam int IDX_W  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNT_W  = $clog2(MAX_SPANS + 1);
  localparam int ENT    = DAY_SLOTS * MAX_SPANS;
  localparam int ADDR_W = $clog2(ENT);
  localparam int IV_W   = 34 + 48;
  localparam int SS_W   = CNT_W + 17 + 48;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DAY_SLOTS - 1);

  // configuration
  logic [15:0] ppl_q;
  logic [19:0] thr_q;
  logic [43:0] wstart_q, wend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q    <= PPL_RST;
      thr_q    <= THR_RST;
      wstart_q <= '0;
      wend_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_PPL:    ppl_q    <= cfg_data_i[15:0];
        CFG_THR:    thr_q    <= cfg_data_i[19:0];
        CFG_WSTART: wstart_q <= cfg_data_i;
        CFG_WEND:   wend_q   <= cfg_data_i;
        default:    ppl_q    <= ppl_q;
      endcase
    end
  end

  // captured word
  logic [2:0]  cmd_q;
  logic [15:0] pulses_q;
  logic        tv_q;
  logic [15:0] day_q;
  logic [16:0] sec_q;
  logic [2:0]  rslot_q;
  logic [3:0]  rent_q;

  // sequencer and state
  state_e state_q, state_d;
  logic              valve_q, ovr_q, obc_q, flowing_q, day_known_q;
  logic [15:0]       day_cur_q;
  logic [SLOT_W-1:0] week_slot_q;
  logic              open_valid_q;
  logic [IDX_W-1:0]  open_idx_q;
  logic [16:0]       open_start_q;
  logic [47:0]       open_vol_q;
  logic [31:0]       rate_q;
  logic [47:0]       total_q;
  logic [CNT_W-1:0]  cur_count_q;
  logic [16:0]       cur_secs_q;
  logic [47:0]       cur_vol_q;
  logic              active_q;
  logic [DAY_SLOTS-1:0] slot_vld_q;

  logic [31:0]      prod_rate_q;
  logic [35:0]      prod_vol_q;
  logic [10:0]      minute_q;
  logic [35:0]      vol_q;
  logic [35:0]      min_prod;

  // memories
  logic [IV_W-1:0] iv_mem [ENT];
  logic [SS_W-1:0] ss_mem [DAY_SLOTS];
  logic [IV_W-1:0] iv_rdata_q;
  logic [SS_W-1:0] ss_rdata_q;
  logic            ss_rvld_q;

  logic              iv_we, ss_we;
  logic [ADDR_W-1:0] iv_waddr, iv_raddr;
  logic [IV_W-1:0]   iv_wdata;
  logic [SS_W-1:0]   ss_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  fmvs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept, out_free, rollover, win, rslot_ok;
  logic start_new, full, nv_valid;
  logic [IDX_W-1:0] nv_idx;
  logic [16:0]      nv_start;
  logic [47:0]      new_ivol, vol48;
  logic [CNT_W-1:0] cnt_nx;
  logic [16:0]      secs_nx;
  logic [47:0]      svol_nx;
  logic [SLOT_W-1:0] slot_nx;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign rollover   = !day_known_q || (day_cur_q != day_q);
  assign slot_nx    = (week_slot_q == LAST_SLOT) ? '0 : week_slot_q + 1'b1;
  assign rslot_ok   = 32'(rslot_q) < DAY_SLOTS;
  assign min_prod   = {19'b0, sec_q} * {17'b0, MIN_RECIP};
  assign vol48      = {12'b0, vol_q};

  assign div_req.start    = (state_q == ST_GO_R) || (state_q == ST_GO_V);
  assign div_req.dividend = (state_q == ST_GO_R) ? {4'b0, prod_rate_q} : prod_vol_q;
  assign div_req.divisor  = (ppl_q == '0) ? 16'd1 : ppl_q;

  // closed window check
  always_comb begin
    logic [10:0] s, e;
    win = 1'b0;
    for (int i = 0; i < WINDOWS; i++) begin
      s = wstart_q[11*i +: 11];
      e = wend_q[11*i +: 11];
      if (s < e) begin
        if (minute_q >= s && minute_q < e) win = 1'b1;
      end else if (s > e) begin
        if (minute_q >= s || minute_q < e) win = 1'b1;
      end
    end
  end

  // span bookkeeping for the update step
  always_comb begin
    start_new = active_q && !flowing_q;
    full      = cur_count_q >= CNT_W'(MAX_SPANS);
    nv_valid  = active_q && (start_new ? !full : open_valid_q);
    nv_idx    = start_new ? IDX_W'(cur_count_q) : open_idx_q;
    nv_start  = start_new ? sec_q : open_start_q;
    new_ivol  = active_q ? sat48(start_new ? 48'd0 : open_vol_q, vol48) : open_vol_q;
    cnt_nx    = cur_count_q + CNT_W'(start_new && !full);
    secs_nx   = (active_q && cur_secs_q < SECS_MAX) ? cur_secs_q + 1'b1 : cur_secs_q;
    svol_nx   = active_q ? sat48(cur_vol_q, vol48) : cur_vol_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = (cmd_e'(cmd_q) == CMD_TICK) ? ST_GO_R : ST_CMD;
      ST_GO_R:  state_d = ST_DIV_R;
      ST_DIV_R: if (div_rsp.done) state_d = tv_q ? ST_ROLL : ST_DONE;
      ST_ROLL:  state_d = (rate_q > {12'b0, thr_q}) ? ST_GO_V : ST_UPD;
      ST_GO_V:  state_d = ST_DIV_V;
      ST_DIV_V: if (div_rsp.done) state_d = ST_UPD;
      ST_UPD:   state_d = ST_DONE;
      ST_CMD:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    iv_we    = 1'b0;
    ss_we    = 1'b0;
    iv_waddr = ADDR_W'(week_slot_q) * ADDR_W'(MAX_SPANS) + ADDR_W'(open_idx_q);
    iv_wdata = {open_start_q, LAST_SEC, open_vol_q};
    ss_wdata = {cnt_nx, secs_nx, svol_nx};
    iv_raddr = ADDR_W'(rslot_q) * ADDR_W'(MAX_SPANS) + ADDR_W'(rent_q);
    case (state_q)
      ST_ROLL: iv_we = rollover && flowing_q && open_valid_q;
      ST_UPD: begin
        iv_we    = (active_q && nv_valid) || (!active_q && flowing_q && open_valid_q);
        iv_waddr = ADDR_W'(week_slot_q) * ADDR_W'(MAX_SPANS) + ADDR_W'(nv_idx);
        iv_wdata = {nv_start, sec_q, new_ivol};
        ss_we    = 1'b1;
      end
      default: iv_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (iv_we) iv_mem[iv_waddr] <= iv_wdata;
    if (ss_we) ss_mem[week_slot_q] <= ss_wdata;
    if (state_q == ST_CMD) begin
      iv_rdata_q <= iv_mem[iv_raddr];
      ss_rdata_q <= ss_mem[SLOT_W'(rslot_q)];
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      pulses_q <= pulses_i;
      tv_q     <= time_valid_i;
      day_q    <= day_id_i;
      sec_q    <= (sec_of_day_i > LAST_SEC) ? LAST_SEC : sec_of_day_i;
      rslot_q  <= read_slot_i;
      rent_q   <= read_entry_i;
    end
    if (state_q == ST_MUL) begin
      prod_rate_q <= {16'b0, pulses_q} * {16'b0, RATE_MUL};
      prod_vol_q  <= {20'b0, pulses_q} * {16'b0, VOL_MUL};
      minute_q    <= min_prod[MIN_SHIFT +: 11];
    end
    if (state_q == ST_DIV_V && div_rsp.done) vol_q <= div_rsp.quotient;
    if (state_q == ST_ROLL) active_q <= rate_q > {12'b0, thr_q};
  end

  // control and logged state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valve_q      <= 1'b1;
      ovr_q        <= 1'b0;
      obc_q        <= 1'b0;
      flowing_q    <= 1'b0;
      day_known_q  <= 1'b0;
      day_cur_q    <= '0;
      week_slot_q  <= LAST_SLOT;
      open_valid_q <= 1'b0;
      open_idx_q   <= '0;
      open_start_q <= '0;
      open_vol_q   <= '0;
      rate_q       <= '0;
      total_q      <= '0;
      cur_count_q  <= '0;
      cur_secs_q   <= '0;
      cur_vol_q    <= '0;
      slot_vld_q   <= '0;
      ss_rvld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_DIV_R: if (div_rsp.done) rate_q <= div_rsp.quotient[31:0];
        ST_ROLL: begin
          if (rollover) begin
            week_slot_q          <= slot_nx;
            slot_vld_q[slot_nx]  <= 1'b0;
            day_known_q          <= 1'b1;
            day_cur_q            <= day_q;
            cur_count_q          <= CNT_W'(flowing_q);
            cur_secs_q           <= '0;
            cur_vol_q            <= '0;
            open_valid_q         <= flowing_q;
            open_idx_q           <= '0;
            open_start_q         <= '0;
            open_vol_q           <= '0;
          end
        end
        ST_UPD: begin
          open_valid_q             <= nv_valid;
          open_idx_q               <= nv_idx;
          open_start_q             <= nv_start;
          open_vol_q               <= new_ivol;
          cur_count_q              <= cnt_nx;
          cur_secs_q               <= secs_nx;
          cur_vol_q                <= svol_nx;
          slot_vld_q[week_slot_q]  <= 1'b1;
          if (active_q) total_q <= sat48(total_q, vol48);
          flowing_q <= active_q;
          if (!ovr_q) begin
            valve_q <= !win;
          end else if (win != obc_q) begin
            ovr_q   <= 1'b0;
            valve_q <= !win;
          end
        end
        ST_CMD: begin
          ss_rvld_q <= rslot_ok && slot_vld_q[SLOT_W'(rslot_q)];
          case (cmd_e'(cmd_q))
            CMD_OPEN, CMD_CLOSE: begin
              ovr_q   <= 1'b1;
              obc_q   <= tv_q && win;
              valve_q <= cmd_e'(cmd_q) == CMD_OPEN;
            end
            CMD_CLR_TOTAL: begin
              total_q <= '0;
              rate_q  <= '0;
            end
            default: ovr_q <= ovr_q;
          endcase
        end
        default: ovr_q <= ovr_q;
      endcase
    end
  end

  // result register
  logic [CNT_W-1:0] rcnt;
  logic             ent_ok, is_read;
  logic             out_valid_q;

  assign is_read = (cmd_e'(cmd_q) == CMD_READ) && rslot_ok;
  assign rcnt    = (is_read && ss_rvld_q) ? ss_rdata_q[SS_W-1 -: CNT_W] : '0;
  assign ent_ok  = 8'(rent_q) < 8'(rcnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      valve_open_o         <= valve_q;
      flow_rate_o          <= rate_q;
      flow_active_o        <= flowing_q;
      override_on_o        <= ovr_q;
      day_active_seconds_o <= cur_secs_q;
      day_volume_o         <= cur_vol_q;
      total_volume_o       <= total_q;
      read_count_o         <= 5'(rcnt);
      read_start_o         <= ent_ok ? iv_rdata_q[IV_W-1 -: 17] : '0;
      read_end_o           <= ent_ok ? iv_rdata_q[64:48] : '0;
      read_volume_o        <= ent_ok ? iv_rdata_q[47:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  `FMVS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, in_stall_o, "accepted word not held")
  `FMVS_ASSERT_IMP(a_open_in_count, clk_i, rst_ni, open_valid_q, CNT_W'(open_idx_q) < cur_count_q, "open span beyond count")
  `FMVS_ASSERT_IMP(a_flow_needs_day, clk_i, rst_ni, flowing_q, day_known_q, "flow without known day")

endmodule

>>> tb/sv/flow_meter_valve_scheduler_tb.sv
// Self-checking testbench for flow_meter_valve_scheduler: a queue-fed driver and a
// monitor compare every result word with a behavioral predictor of the block.
// Depends on fmvs_pkg and the top level RTL only.
module flow_meter_valve_scheduler_tb;
  import fmvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] pulses;
    logic        tvalid;
    logic [15:0] day;
    logic [16:0] sec;
    logic [2:0]  rslot;
    logic [3:0]  rentry;
  } meter_word_t;

  typedef struct {
    logic        valve;
    logic [31:0] rate;
    logic        active;
    logic        ovr;
    logic [16:0] dsecs;
    logic [47:0] dvol;
    logic [47:0] tvol;
    logic [4:0]  rcount;
    logic [16:0] rstart;
    logic [16:0] rend;
    logic [47:0] rvol;
  } meter_status_t;

  localparam int NSLOT = 7;
  localparam int NSPAN = 16;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [43:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [15:0] pulses_i = '0;
  logic        time_valid_i = 1'b0;
  logic [15:0] day_id_i = '0;
  logic [16:0] sec_of_day_i = '0;
  logic [2:0]  read_slot_i = '0;
  logic [3:0]  read_entry_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valve_open_o;
  logic [31:0] flow_rate_o;
  logic        flow_active_o;
  logic        override_on_o;
  logic [16:0] day_active_seconds_o;
  logic [47:0] day_volume_o;
  logic [47:0] total_volume_o;
  logic [4:0]  read_count_o;
  logic [16:0] read_start_o;
  logic [16:0] read_end_o;
  logic [47:0] read_volume_o;

  flow_meter_valve_scheduler u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] m_ppl = PPL_RST;
  logic [19:0] m_thr = THR_RST;
  logic [43:0] m_wstart = '0;
  logic [43:0] m_wend = '0;
  logic        m_valve = 1'b1;
  logic        m_ovr = 1'b0;
  logic        m_ovr_closed = 1'b0;
  logic        m_flowing = 1'b0;
  logic        m_day_known = 1'b0;
  logic [15:0] m_day = '0;
  int          m_slot = NSLOT - 1;
  logic        m_open_v = 1'b0;
  int          m_open_ix = 0;
  logic [31:0] m_rate = '0;
  logic [47:0] m_total = '0;
  logic [4:0]  m_cnt[NSLOT] = '{default: '0};
  logic [16:0] m_secs[NSLOT] = '{default: '0};
  logic [47:0] m_svol[NSLOT] = '{default: '0};
  logic [16:0] m_ist[NSLOT*NSPAN];
  logic [16:0] m_iend[NSLOT*NSPAN];
  logic [47:0] m_ivol[NSLOT*NSPAN];

  meter_word_t   pending_words[$];
  meter_status_t expected_status[$];
  meter_word_t   cur_word;
  bit            holding = 0;
  int            send_idle = 0;
  int            recv_stall = 0;
  int            errors = 0;
  int            n_words = 0;
  int            n_checked = 0;
  int            n_reads = 0;
  int            quiet = 0;

  function automatic logic [47:0] vol_add(logic [47:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {16'd0, a} + b;
    return (s > {16'd0, VOL_MAX}) ? VOL_MAX : s[47:0];
  endfunction

  function automatic logic in_window(int minute);
    int s;
    int e;
    for (int i = 0; i < 4; i++) begin
      s = int'((m_wstart >> (11 * i)) & 44'h7FF);
      e = int'((m_wend >> (11 * i)) & 44'h7FF);
      if (s == e) continue;
      if (s < e) begin
        if (minute >= s && minute < e) return 1'b1;
      end else if (minute >= s || minute < e) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic span_begin(int sec);
    int k;
    if (m_cnt[m_slot] >= NSPAN) begin
      m_open_v = 1'b0;
    end else begin
      k = m_slot * NSPAN + int'(m_cnt[m_slot]);
      m_open_v = 1'b1;
      m_open_ix = int'(m_cnt[m_slot]);
      m_ist[k] = 17'(sec);
      m_iend[k] = 17'(sec);
      m_ivol[k] = '0;
      m_cnt[m_slot] = m_cnt[m_slot] + 5'd1;
    end
  endtask

  task automatic span_mark(int sec);
    if (m_open_v) m_iend[m_slot * NSPAN + m_open_ix] = 17'(sec);
  endtask

  task automatic meter_step(input meter_word_t w, output meter_status_t r);
    logic [63:0] ppl;
    logic [63:0] vol;
    int          sec;
    int          k;
    logic        act;
    logic        win;
    ppl = (m_ppl == 0) ? 64'd1 : {48'd0, m_ppl};
    sec = int'((w.sec > LAST_SEC) ? LAST_SEC : w.sec);
    r.rcount = '0;
    r.rstart = '0;
    r.rend = '0;
    r.rvol = '0;
    case (w.cmd)
      CMD_TICK: begin
        m_rate = 32'((64'(w.pulses) * 64'd60000) / ppl);
        if (w.tvalid) begin
          if (!m_day_known || m_day != w.day) begin
            if (m_flowing) begin
              span_mark(int'(LAST_SEC));
              m_open_v = 1'b0;
            end
            m_slot = (m_slot + 1) % NSLOT;
            m_cnt[m_slot] = '0;
            m_secs[m_slot] = '0;
            m_svol[m_slot] = '0;
            m_day_known = 1'b1;
            m_day = w.day;
            if (m_flowing) span_begin(0);
          end
          act = m_rate > {12'd0, m_thr};
          if (act && !m_flowing) span_begin(sec);
          else if (!act && m_flowing) begin
            span_mark(sec);
            m_open_v = 1'b0;
          end
          if (act) begin
            vol = (64'(w.pulses) * 64'd1000000) / ppl;
            if (m_secs[m_slot] < SECS_MAX) m_secs[m_slot] = m_secs[m_slot] + 17'd1;
            m_svol[m_slot] = vol_add(m_svol[m_slot], vol);
            m_total = vol_add(m_total, vol);
            if (m_open_v) begin
              k = m_slot * NSPAN + m_open_ix;
              m_ivol[k] = vol_add(m_ivol[k], vol);
              span_mark(sec);
            end
          end
          m_flowing = act;
          win = in_window(sec / 60);
          if (m_ovr) begin
            if (win != m_ovr_closed) begin
              m_ovr = 1'b0;
              m_valve = !win;
            end
          end else begin
            m_valve = !win;
          end
        end
      end
      CMD_OPEN, CMD_CLOSE: begin
        m_ovr = 1'b1;
        m_ovr_closed = w.tvalid ? in_window(sec / 60) : 1'b0;
        m_valve = (w.cmd == CMD_OPEN);
      end
      CMD_CLR_TOTAL: begin
        m_total = '0;
        m_rate = '0;
      end
      CMD_READ: begin
        if (int'(w.rslot) < NSLOT) begin
          r.rcount = m_cnt[w.rslot];
          if ({1'b0, w.rentry} < m_cnt[w.rslot]) begin
            k = int'(w.rslot) * NSPAN + int'(w.rentry);
            r.rstart = m_ist[k];
            r.rend = m_iend[k];
            r.rvol = m_ivol[k];
          end
        end
      end
      default: ;
    endcase
    r.valve = m_valve;
    r.rate = m_rate;
    r.active = m_flowing;
    r.ovr = m_ovr;
    r.dsecs = m_secs[m_slot];
    r.dvol = m_svol[m_slot];
    r.tvol = m_total;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    meter_status_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        meter_step(cur_word, r);
        expected_status.push_back(r);
        n_words++;
        if (cur_word.cmd == CMD_READ) n_reads++;
        holding = 0;
      end
      if (!holding) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_word = pending_words.pop_front();
          command_i <= cur_word.cmd;
          pulses_i <= cur_word.pulses;
          time_valid_i <= cur_word.tvalid;
          day_id_i <= cur_word.day;
          sec_of_day_i <= cur_word.sec;
          read_slot_i <= cur_word.rslot;
          read_entry_i <= cur_word.rentry;
          in_valid_i <= 1'b1;
          holding = 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    meter_status_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_status.pop_front();
          check_field("valve_open", 64'(e.valve), 64'(valve_open_o));
          check_field("flow_rate", 64'(e.rate), 64'(flow_rate_o));
          check_field("flow_active", 64'(e.active), 64'(flow_active_o));
          check_field("override_on", 64'(e.ovr), 64'(override_on_o));
          check_field("day_active_seconds", 64'(e.dsecs), 64'(day_active_seconds_o));
          check_field("day_volume", 64'(e.dvol), 64'(day_volume_o));
          check_field("total_volume", 64'(e.tvol), 64'(total_volume_o));
          check_field("read_count", 64'(e.rcount), 64'(read_count_o));
          check_field("read_start", 64'(e.rstart), 64'(read_start_o));
          check_field("read_end", 64'(e.rend), 64'(read_end_o));
          check_field("read_volume", 64'(e.rvol), 64'(read_volume_o));
          n_checked++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_words.size() == 0 && expected_status.size() == 0)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic cfg_write(cfg_e idx, logic [43:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_PPL:    m_ppl = data[15:0];
      CFG_THR:    m_thr = data[19:0];
      CFG_WSTART: m_wstart = data;
      default:    m_wend = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_word(cmd_e c, logic [15:0] p, logic tv, logic [15:0] d,
                          logic [16:0] s, logic [2:0] rs, logic [3:0] re);
    meter_word_t w;
    w.cmd = c;
    w.pulses = p;
    w.tvalid = tv;
    w.day = d;
    w.sec = s;
    w.rslot = rs;
    w.rentry = re;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_status.size() > 0 || holding)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  logic [15:0] g_day;
  int          g_sec;
  bit          g_flow;

  task automatic gen_random(int n);
    int   pick;
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(99));
      if ($urandom_range(9) == 0) g_flow = !g_flow;
      if ($urandom_range(199) == 0 || g_sec >= 86399) begin
        g_day = g_day + 16'($urandom_range(1, 3));
        g_sec = int'($urandom_range(0, 50));
      end else if ($urandom_range(19) == 0) begin
        g_sec = int'($urandom_range(g_sec, 86399));
      end else begin
        g_sec = g_sec + int'($urandom_range(1, 90));
        if (g_sec > 86399) g_sec = 86399;
      end
      if (!g_flow) p = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'd0;
      else if ($urandom_range(9) == 0) p = 16'($urandom());
      else p = 16'($urandom_range(1, 400));
      if (pick < 78)
        add_word(CMD_TICK, p, $urandom_range(19) != 0, g_day, 17'(g_sec), '0, '0);
      else if (pick < 83)
        add_word(CMD_OPEN, 16'($urandom()), 1'($urandom_range(1)), g_day,
                 17'($urandom_range(86399)), '0, '0);
      else if (pick < 88)
        add_word(CMD_CLOSE, 16'($urandom()), 1'($urandom_range(1)), g_day,
                 17'($urandom_range(86399)), '0, '0);
      else if (pick < 90)
        add_word(CMD_CLR_TOTAL, 16'($urandom()), 1'($urandom_range(1)), g_day,
                 17'(g_sec), '0, '0);
      else
        add_word(CMD_READ, 16'($urandom()), 1'($urandom_range(1)), 16'($urandom()),
                 17'($urandom_range(86399)), 3'($urandom_range(6)),
                 4'($urandom_range(15)));
    end
  endtask

  function automatic logic [43:0] rand_windows();
    logic [43:0] v;
    for (int i = 0; i < 4; i++)
      v[11*i +: 11] = ($urandom_range(7) == 0) ? 11'($urandom()) : 11'($urandom_range(1439));
    return v;
  endfunction

  initial begin
    int idle_tab[4][2];
    idle_tab = '{'{0, 0}, '{75, 0}, '{0, 75}, '{6, 6}};
    g_day = 16'd100;
    g_sec = 0;
    g_flow = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // directed
    add_word(CMD_TICK, 16'hFFFF, 1'b0, 16'd0, 17'd0, '0, '0);
    add_word(CMD_OPEN, 16'd0, 1'b0, 16'd0, 17'd0, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd0, 17'd0, '0, '0);
    add_word(CMD_TICK, 16'd300, 1'b1, 16'd0, 17'd10, '0, '0);
    add_word(CMD_TICK, 16'hFFFF, 1'b1, 16'd0, 17'd86399, '0, '0);
    add_word(CMD_TICK, 16'd50, 1'b1, 16'hFFFF, 17'd5, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'hFFFF, 17'd6, '0, '0);
    add_word(CMD_READ, 16'hFFFF, 1'b1, 16'hFFFF, 17'd86399, 3'd0, 4'd0);
    add_word(CMD_READ, 16'd0, 1'b0, 16'd0, 17'd0, 3'd6, 4'd0);
    add_word(CMD_READ, 16'd0, 1'b0, 16'd0, 17'd0, 3'd1, 4'd1);
    add_word(CMD_READ, 16'd0, 1'b0, 16'd0, 17'd0, 3'd0, 4'd15);
    add_word(CMD_CLOSE, 16'hFFFF, 1'b1, 16'd0, 17'd86399, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'hFFFF, 17'd100, '0, '0);
    add_word(CMD_CLR_TOTAL, 16'hFFFF, 1'b1, 16'd0, 17'd0, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'hFFFF, 17'd200, '0, '0);
    drain();

    // wrapping windows and manual overrides across them
    cfg_write(CFG_WSTART, {11'd2047, 11'd5, 11'd1430, 11'd1});
    cfg_write(CFG_WEND, {11'd0, 11'd5, 11'd10, 11'd3});
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd7, 17'd60, '0, '0);
    add_word(CMD_OPEN, 16'd0, 1'b1, 16'd7, 17'd60, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd7, 17'd120, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd7, 17'd200, '0, '0);
    add_word(CMD_CLOSE, 16'd0, 1'b1, 16'd7, 17'd300, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd7, 17'd86350, '0, '0);
    add_word(CMD_TICK, 16'd0, 1'b1, 16'd8, 17'd500, '0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_PPL, 44'd450);
          cfg_write(CFG_THR, 44'd100);
        end
        1: begin
          cfg_write(CFG_PPL, 44'd1);
          cfg_write(CFG_THR, 44'd1000000);
        end
        2: begin
          cfg_write(CFG_PPL, 44'd65535);
          cfg_write(CFG_THR, 44'd0);
        end
        3: cfg_write(CFG_WEND, 44'h0);
        default: begin
          cfg_write(CFG_PPL, 44'($urandom_range(1, 2000)));
          cfg_write(CFG_THR, 44'($urandom_range(0, 3000)));
        end
      endcase
      cfg_write(CFG_WSTART, rand_windows());
      if (ph != 3) cfg_write(CFG_WEND, rand_windows());
      send_idle = idle_tab[ph % 4][0];
      recv_stall = idle_tab[ph % 4][1];
      gen_random(185);
      drain();
    end

    $display("%0d words sent, %0d results checked, %0d interval reads", n_words,
             n_checked, n_reads);
    $display("covered ticks, overrides, total clears, day rollovers and window settings");
    if (errors == 0 && expected_status.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
